>>> rtl/ibfr_pkg.sv
// Shared types and constants for the serial servo frame receiver.
// Used by every module under rtl except ibfr_ram; has no dependencies of its own.
package ibfr_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_HDR_FIRST  = 3'd0;
	localparam logic [2:0] REG_HDR_SECOND = 3'd1;
	localparam logic [2:0] REG_CSUM_BASE  = 3'd2;
	localparam logic [2:0] REG_FS_COUNT   = 3'd3;
	localparam logic [2:0] REG_FS_LIMIT   = 3'd4;

	// Reset values of the configuration registers
	localparam logic [7:0]  RST_HDR_FIRST  = 8'h20;
	localparam logic [7:0]  RST_HDR_SECOND = 8'h40;
	localparam logic [15:0] RST_CSUM_BASE  = 16'hFFFF;
	localparam logic [3:0]  RST_FS_COUNT   = 4'd4;
	localparam logic [15:0] RST_FS_LIMIT   = 16'h0000;

	typedef struct packed {
		logic [7:0]  hdr_first;
		logic [7:0]  hdr_second;
		logic [15:0] csum_base;
		logic [3:0]  fs_count;
		logic [15:0] fs_limit;
	} ibfr_cfg_t;

	// One checked frame waiting for the back end: which buffer bank holds it
	typedef struct packed {
		logic bank;
	} ibfr_cmd_t;

	typedef struct packed {
		logic valid;
		logic full;
	} ibfr_qstat_t;

endpackage

>>> rtl/ibfr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ibfr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/ibfr_front.sv
// Front end: header hunt, byte capture into the frame buffer, checksum check.
// Depends on ibfr_pkg; writes ibfr_ram and pushes checked frames to ibfr_cmdq.
module ibfr_front #(
	parameter int FRAME_BYTES = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ibfr_pkg::ibfr_cfg_t             cfg,
	input  logic                            in_valid,
	input  logic [7:0]                      in_byte,
	output logic                            in_ready,
	output logic                            wr_en,
	output logic [$clog2(FRAME_BYTES)-1:0]  wr_addr,
	output logic [15:0]                     wr_data,
	output logic                            push,
	output ibfr_pkg::ibfr_cmd_t             push_cmd,
	input  logic                            done
);

	localparam int PW = $clog2(FRAME_BYTES);
	localparam logic [PW-1:0] POS_CSUM_LO = PW'(FRAME_BYTES - 2);
	localparam logic [PW-1:0] POS_LAST    = PW'(FRAME_BYTES - 1);

	logic [PW-1:0] pos_q;
	logic [15:0]   sum_q;
	logic [7:0]    lo_q;
	logic [7:0]    csum_lo_q;
	logic          wbank_q;
	logic [1:0]    busy_cnt_q;

	logic          accept;
	logic          body;
	logic          good;

	// Two banks: stall only when both hold frames not yet fully sent
	assign in_ready = (busy_cnt_q != 2'd2);
	assign accept   = in_valid && in_ready;
	assign body     = (pos_q != PW'(0)) && (pos_q != PW'(1));
	assign good     = ({in_byte, csum_lo_q} == (cfg.csum_base - sum_q));

	assign push          = accept && (pos_q == POS_LAST) && good;
	assign push_cmd.bank = wbank_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = {wbank_q, pos_q[PW-1:1]};
		wr_data = {in_byte, lo_q};
		if (accept && body) begin
			if (pos_q[0]) begin
				wr_en = 1'b1;
			end else if (pos_q == POS_LAST) begin
				// odd frame length: lone low byte, high byte reads as zero
				wr_en   = 1'b1;
				wr_data = {8'h00, in_byte};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			wbank_q    <= 1'b0;
			busy_cnt_q <= 2'd0;
		end else begin
			if (push && !done) begin
				busy_cnt_q <= busy_cnt_q + 2'd1;
			end else if (done && !push) begin
				busy_cnt_q <= busy_cnt_q - 2'd1;
			end
			if (push) begin
				wbank_q <= ~wbank_q;
			end
			if (accept) begin
				if (pos_q == PW'(0)) begin
					if (in_byte == cfg.hdr_first) begin
						pos_q <= PW'(1);
					end
				end else if (pos_q == PW'(1)) begin
					// wrong second byte: back to hunting, byte is not retried
					pos_q <= (in_byte == cfg.hdr_second) ? PW'(2) : PW'(0);
				end else if (pos_q == POS_LAST) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + PW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (pos_q == PW'(0)) begin
				sum_q <= {8'h00, in_byte};
			end else if (pos_q < POS_CSUM_LO) begin
				sum_q <= sum_q + {8'h00, in_byte};
			end
			if (pos_q == POS_CSUM_LO) begin
				csum_lo_q <= in_byte;
			end
			if (!pos_q[0]) begin
				lo_q <= in_byte;
			end
		end
	end

endmodule

>>> rtl/ibfr_cmdq.sv
// Two-entry queue of checked frames between the front and back ends.
// Depends on ibfr_pkg.
module ibfr_cmdq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ibfr_pkg::ibfr_cmd_t   push_cmd,
	input  logic                  pop,
	output ibfr_pkg::ibfr_cmd_t   head,
	output ibfr_pkg::ibfr_qstat_t stat
);

	ibfr_pkg::ibfr_cmd_t ent_q [2];
	logic                wptr_q;
	logic                rptr_q;
	logic [1:0]          cnt_q;

	assign head       = ent_q[rptr_q];
	assign stat.valid = (cnt_q != 2'd0);
	assign stat.full  = (cnt_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_cmd;
		end
	end

endmodule

>>> rtl/ibfr_back.sv
// Back end: failsafe sum over the leading channels, then the channel run.
// Depends on ibfr_pkg; reads the frame buffer and pops ibfr_cmdq.
module ibfr_back #(
	parameter int FRAME_BYTES = 32,
	parameter int CHANNELS    = 14
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ibfr_pkg::ibfr_cfg_t             cfg,
	input  ibfr_pkg::ibfr_cmd_t             head,
	input  ibfr_pkg::ibfr_qstat_t           qstat,
	output logic                            pop,
	output logic                            rd_en,
	output logic [$clog2(FRAME_BYTES)-1:0]  rd_addr,
	input  logic [15:0]                     rd_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [3:0]                      out_index,
	output logic [15:0]                     out_value,
	output logic                            out_failsafe,
	output logic                            out_last,
	output logic                            done
);

	localparam int PW = $clog2(FRAME_BYTES);
	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	// channels whose low byte lies inside the frame
	localparam int NWORDS = (FRAME_BYTES - 1) / 2;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SRD  = 3'd1;
	localparam logic [2:0] ST_SACC = 3'd2;
	localparam logic [2:0] ST_SCMP = 3'd3;
	localparam logic [2:0] ST_ERD  = 3'd4;
	localparam logic [2:0] ST_ELD  = 3'd5;
	localparam logic [2:0] ST_EOUT = 3'd6;

	logic [2:0]    state_q;
	logic [CW-1:0] ch_q;
	logic          bank_q;
	logic [15:0]   sum_q;
	logic          fs_q;
	logic          wvalid_q;
	logic [CW:0]   ch_inc;
	logic          ch_in_frame;
	logic [4:0]    n_eff;
	logic [15:0]   word;
	logic          is_last;

	assign ch_inc      = {1'b0, ch_q} + (CW+1)'(1);
	assign ch_in_frame = (int'(ch_q) < NWORDS);
	assign n_eff       = (int'(cfg.fs_count) > CHANNELS) ? 5'(CHANNELS) : {1'b0, cfg.fs_count};
	assign word        = wvalid_q ? rd_data : 16'h0000;
	assign is_last     = (int'(ch_q) == CHANNELS - 1);

	assign pop     = (state_q == ST_IDLE) && qstat.valid;
	assign rd_en   = (state_q == ST_SRD) || (state_q == ST_ERD);
	assign rd_addr = {bank_q, (PW-1)'(ch_inc)};
	assign done    = (state_q == ST_EOUT) && out_ready && out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (qstat.valid) begin
						state_q <= (n_eff == 5'd0) ? ST_SCMP : ST_SRD;
					end
				end
				ST_SRD: begin
					state_q <= ST_SACC;
				end
				ST_SACC: begin
					state_q <= (int'(ch_inc) == int'(n_eff)) ? ST_SCMP : ST_SRD;
				end
				ST_SCMP: begin
					state_q <= ST_ERD;
				end
				ST_ERD: begin
					state_q <= ST_ELD;
				end
				ST_ELD: begin
					out_valid <= 1'b1;
					state_q   <= ST_EOUT;
				end
				ST_EOUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= out_last ? ST_IDLE : ST_ERD;
					end
				end
				default: begin
					state_q   <= ST_IDLE;
					out_valid <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ch_q   <= '0;
				sum_q  <= '0;
				bank_q <= head.bank;
			end
			ST_SRD, ST_ERD: begin
				wvalid_q <= ch_in_frame;
			end
			ST_SACC: begin
				sum_q <= sum_q + word;
				ch_q  <= CW'(ch_inc);
			end
			ST_SCMP: begin
				fs_q <= (sum_q <= cfg.fs_limit);
				ch_q <= '0;
			end
			ST_ELD: begin
				out_index    <= 4'(ch_q);
				out_value    <= word;
				out_failsafe <= fs_q;
				out_last     <= is_last;
			end
			ST_EOUT: begin
				if (out_ready) begin
					ch_q <= CW'(ch_inc);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/ibus_frame_receiver_unit.sv
// Top level of the serial servo frame receiver: config registers and wiring.
// Depends on ibfr_pkg, ibfr_ram, ibfr_front, ibfr_cmdq and ibfr_back.
//
//  channel  | direction | signals                                  | content
//  s_*      | in        | s_tvalid s_tready s_tdata[7:0]           | rx_byte
//  m_*      | out       | m_tvalid m_tready m_tdata m_tuser m_tlast | one channel result
//  cfg_*    | in        | cfg_valid cfg_ready cfg_index cfg_data   | register write
//
// One received byte is taken per cycle while either frame buffer bank is free.
// For a good frame the back end first sums the N leading channels for the
// failsafe check, then sends each channel through its single buffer read port
// and output register. Input stalls only while both banks hold checked frames
// not yet fully sent. Reset sets the default registers and starts hunting for a header.
module ibus_frame_receiver_unit #(
	parameter int FRAME_BYTES = 32,
	parameter int CHANNELS    = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [3:0] channel_index, [19:4] channel_value, zero fill
	output logic [0:0]  m_tuser,   // [0] failsafe
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int PW = $clog2(FRAME_BYTES);

	ibfr_pkg::ibfr_cfg_t   cfg_q;
	ibfr_pkg::ibfr_cmd_t   push_cmd;
	ibfr_pkg::ibfr_cmd_t   head;
	ibfr_pkg::ibfr_qstat_t qstat;

	logic          push;
	logic          pop;
	logic          done;
	logic          wr_en;
	logic [PW-1:0] wr_addr;
	logic [15:0]   wr_data;
	logic          rd_en;
	logic [PW-1:0] rd_addr;
	logic [15:0]   rd_data;
	logic [3:0]    out_index;
	logic [15:0]   out_value;
	logic          out_failsafe;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hdr_first  <= ibfr_pkg::RST_HDR_FIRST;
			cfg_q.hdr_second <= ibfr_pkg::RST_HDR_SECOND;
			cfg_q.csum_base  <= ibfr_pkg::RST_CSUM_BASE;
			cfg_q.fs_count   <= ibfr_pkg::RST_FS_COUNT;
			cfg_q.fs_limit   <= ibfr_pkg::RST_FS_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ibfr_pkg::REG_HDR_FIRST:  cfg_q.hdr_first  <= cfg_data[7:0];
				ibfr_pkg::REG_HDR_SECOND: cfg_q.hdr_second <= cfg_data[7:0];
				ibfr_pkg::REG_CSUM_BASE:  cfg_q.csum_base  <= cfg_data;
				ibfr_pkg::REG_FS_COUNT:   cfg_q.fs_count   <= cfg_data[3:0];
				ibfr_pkg::REG_FS_LIMIT:   cfg_q.fs_limit   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ibfr_ram #(
		.WIDTH(16),
		.DEPTH(2 ** PW)
	) u_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ibfr_front #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.in_ready (s_tready),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.push     (push),
		.push_cmd (push_cmd),
		.done     (done)
	);

	ibfr_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (qstat)
	);

	ibfr_back #(
		.FRAME_BYTES(FRAME_BYTES),
		.CHANNELS   (CHANNELS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_index    (out_index),
		.out_value    (out_value),
		.out_failsafe (out_failsafe),
		.out_last     (m_tlast),
		.done         (done)
	);

	assign m_tdata    = {4'h0, out_value, out_index};
	assign m_tuser[0] = out_failsafe;

	// Queue never overflows: bank accounting in the front end bounds it
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("frame queue push while full");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qstat.valid)
		else $error("frame queue pop while empty");

	// Back end returns to idle after the last channel of a run
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
		else $error("result after end of run without a new frame");

	// A frame completes only when the input may still be taken
	a_push_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (s_tvalid && s_tready))
		else $error("frame pushed without an accepted byte");

endmodule
